// ===== sv/md4_pkg.sv =====
// ----------------------------------------------------------------------------
// md4_pkg
// Item types, initial vector and step tables for the MD4 hash engine.
// ----------------------------------------------------------------------------
package md4_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } t_out_item;

    localparam int STEPS = 48;

    localparam logic [31:0] IV [4] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
    };

    localparam logic [31:0] K_G = 32'h5a827999;
    localparam logic [31:0] K_H = 32'h6ed9eba1;

    localparam logic [3:0] WORD_ORDER [STEPS] = '{
        4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
        4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15,
        4'd0, 4'd4, 4'd8, 4'd12, 4'd1, 4'd5, 4'd9, 4'd13,
        4'd2, 4'd6, 4'd10, 4'd14, 4'd3, 4'd7, 4'd11, 4'd15,
        4'd0, 4'd8, 4'd4, 4'd12, 4'd2, 4'd10, 4'd6, 4'd14,
        4'd1, 4'd9, 4'd5, 4'd13, 4'd3, 4'd11, 4'd7, 4'd15
    };

    localparam logic [4:0] ROT_AMOUNT [12] = '{
        5'd3, 5'd7, 5'd11, 5'd19, 5'd3, 5'd5, 5'd9, 5'd13,
        5'd3, 5'd9, 5'd11, 5'd15
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;

endpackage

// ===== sv/md4_ram.sv =====
// ----------------------------------------------------------------------------
// md4_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module md4_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/md4_round.sv =====
// ----------------------------------------------------------------------------
// md4_round
// One MD4 step: round function, constant, add and rotate.
// ----------------------------------------------------------------------------
module md4_round (
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic [31:0] i_c,
    input  logic [31:0] i_d,
    input  logic [31:0] i_m,
    input  logic [5:0]  i_step,
    output logic [31:0] o_a_new
);

    logic [31:0] f;
    logic [31:0] k;
    logic [31:0] sum;
    logic [4:0]  s;
    logic [3:0]  rot_idx;

    always_comb begin
        case (i_step[5:4])
            2'd0: begin
                f = (i_b & i_c) | (~i_b & i_d);
                k = 32'd0;
            end
            2'd1: begin
                f = (i_b & i_c) | (i_b & i_d) | (i_c & i_d);
                k = md4_pkg::K_G;
            end
            default: begin
                f = i_b ^ i_c ^ i_d;
                k = md4_pkg::K_H;
            end
        endcase
    end

    assign rot_idx = {i_step[5:4], i_step[1:0]};
    assign s       = md4_pkg::ROT_AMOUNT[rot_idx];
    assign sum     = i_a + f + i_m + k;
    assign o_a_new = (sum << s) | (sum >> (6'd32 - {1'b0, s}));

endmodule

// ===== sv/md4_hash_engine.sv =====
// ----------------------------------------------------------------------------
// md4_hash_engine
// Streaming MD4 digest: byte buffer RAM, chaining RAM, one step per cycle.
// ----------------------------------------------------------------------------
// One message byte is taken per item in a cycle; every fourth byte is written
// as a little-endian word to a 16x32 block RAM. A full block stalls input while
// the chaining words load from their 4x32 RAM, the 48 compression steps run
// (one per cycle, limited by the single block RAM read port), and the results
// are added back into the chaining RAM. End of message pads the block (up to 16
// word writes), compresses once or twice, and then presents the four digest
// words, word 0 first, before input is taken again.
module md4_hash_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  md4_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output md4_pkg::t_out_item  o_out_item
);

    typedef enum logic [2:0] {
        S_IDLE, S_PAD, S_FILL, S_LOAD, S_STEP, S_ADD, S_OUT
    } t_state;

    t_state      r_state;
    logic [5:0]  r_fill;
    logic [60:0] r_msg;
    logic [31:0] r_acc;
    logic        r_fin;
    logic        r_padded;
    logic        r_lenblk;
    logic [3:0]  r_wi;
    logic [2:0]  r_cnt;
    logic [5:0]  r_step;
    logic [1:0]  r_oi;
    logic [3:0]  r_cv_valid;
    logic [31:0] r_v [4];

    logic        buf_we;
    logic [3:0]  buf_waddr;
    logic [31:0] buf_wdata;
    logic [3:0]  buf_raddr;
    logic [31:0] buf_rdata;
    logic        cv_we;
    logic [31:0] cv_wdata;
    logic [31:0] cv_rdata;
    logic [31:0] cv_eff;
    logic [2:0]  cnt_m1;
    logic [1:0]  cidx;
    logic [31:0] pad_word;
    logic [31:0] fill_word;
    logic [63:0] bit_len;
    logic [31:0] a_new;
    logic [5:0]  step_nx;

    assign bit_len = {r_msg, 3'b000};
    assign cnt_m1  = r_cnt - 3'd1;
    assign cidx    = cnt_m1[1:0];
    assign cv_eff  = r_cv_valid[cidx] ? cv_rdata : md4_pkg::IV[cidx];
    assign step_nx = r_step + 6'd1;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            if (k[1:0] < r_fill[1:0]) begin
                pad_word[8*k +: 8] = r_acc[8*k +: 8];
            end else if (k[1:0] == r_fill[1:0]) begin
                pad_word[8*k +: 8] = md4_pkg::PAD_BYTE;
            end else begin
                pad_word[8*k +: 8] = 8'd0;
            end
        end
    end

    always_comb begin
        fill_word = 32'd0;
        if (r_lenblk && r_wi == 4'd14) begin
            fill_word = bit_len[31:0];
        end else if (r_lenblk && r_wi == 4'd15) begin
            fill_word = bit_len[63:32];
        end
    end

    always_comb begin
        buf_we    = 1'b0;
        buf_waddr = r_fill[5:2];
        buf_wdata = {i_in_item.data_byte, r_acc[23:0]};
        buf_raddr = 4'd0;
        case (r_state)
            S_IDLE: begin
                buf_we = i_in_valid && i_in_item.has_byte && (r_fill[1:0] == 2'd3);
            end
            S_PAD: begin
                buf_we    = 1'b1;
                buf_wdata = pad_word;
            end
            S_FILL: begin
                buf_we    = 1'b1;
                buf_waddr = r_wi;
                buf_wdata = fill_word;
            end
            S_LOAD: begin
                buf_raddr = md4_pkg::WORD_ORDER[0];
            end
            S_STEP: begin
                if (r_step != 6'(md4_pkg::STEPS - 1)) begin
                    buf_raddr = md4_pkg::WORD_ORDER[step_nx];
                end
            end
            default: begin
                buf_we = 1'b0;
            end
        endcase
    end

    assign cv_we    = (r_state == S_ADD) && (r_cnt != 3'd0);
    assign cv_wdata = cv_eff + r_v[cidx];

    md4_ram #(.WIDTH(32), .DEPTH(16)) u_buf (
        .i_clk   (i_clk),
        .i_we    (buf_we),
        .i_waddr (buf_waddr),
        .i_wdata (buf_wdata),
        .i_raddr (buf_raddr),
        .o_rdata (buf_rdata)
    );

    md4_ram #(.WIDTH(32), .DEPTH(4)) u_chain (
        .i_clk   (i_clk),
        .i_we    (cv_we),
        .i_waddr (cidx),
        .i_wdata (cv_wdata),
        .i_raddr (r_cnt[1:0]),
        .o_rdata (cv_rdata)
    );

    md4_round u_round (
        .i_a     (r_v[0]),
        .i_b     (r_v[1]),
        .i_c     (r_v[2]),
        .i_d     (r_v[3]),
        .i_m     (buf_rdata),
        .i_step  (r_step),
        .o_a_new (a_new)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_fill     <= '0;
            r_msg      <= '0;
            r_fin      <= 1'b0;
            r_padded   <= 1'b0;
            r_lenblk   <= 1'b0;
            r_wi       <= '0;
            r_cnt      <= '0;
            r_step     <= '0;
            r_oi       <= '0;
            r_cv_valid <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        if (i_in_item.has_byte) begin
                            r_acc[8*r_fill[1:0] +: 8] <= i_in_item.data_byte;
                            r_msg <= r_msg + 61'd1;
                            if (r_fill == 6'd63) begin
                                r_fill  <= '0;
                                r_fin   <= i_in_item.end_of_message;
                                r_cnt   <= '0;
                                r_state <= S_LOAD;
                            end else begin
                                r_fill <= r_fill + 6'd1;
                                if (i_in_item.end_of_message) begin
                                    r_fin   <= 1'b1;
                                    r_state <= S_PAD;
                                end
                            end
                        end else if (i_in_item.end_of_message) begin
                            r_fin   <= 1'b1;
                            r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    r_padded <= 1'b1;
                    r_lenblk <= (r_fill < 6'd56);
                    if (r_fill[5:2] == 4'd15) begin
                        r_cnt   <= '0;
                        r_state <= S_LOAD;
                    end else begin
                        r_wi    <= r_fill[5:2] + 4'd1;
                        r_state <= S_FILL;
                    end
                end
                S_FILL: begin
                    if (r_wi == 4'd15) begin
                        r_cnt   <= '0;
                        r_state <= S_LOAD;
                    end else begin
                        r_wi <= r_wi + 4'd1;
                    end
                end
                S_LOAD: begin
                    if (r_cnt != 3'd0) begin
                        r_v[cidx] <= cv_eff;
                    end
                    if (r_cnt == 3'd4) begin
                        r_step  <= '0;
                        r_state <= S_STEP;
                    end else begin
                        r_cnt <= r_cnt + 3'd1;
                    end
                end
                S_STEP: begin
                    // rotate so the word being updated is always in slot 0
                    r_v[0] <= r_v[3];
                    r_v[1] <= a_new;
                    r_v[2] <= r_v[1];
                    r_v[3] <= r_v[2];
                    if (r_step == 6'(md4_pkg::STEPS - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_ADD;
                    end else begin
                        r_step <= step_nx;
                    end
                end
                S_ADD: begin
                    if (r_cnt != 3'd0) begin
                        r_v[cidx] <= cv_wdata;
                    end
                    if (r_cnt == 3'd4) begin
                        r_cv_valid <= 4'hf;
                        if (!r_fin) begin
                            r_state <= S_IDLE;
                        end else if (!r_padded) begin
                            r_state <= S_PAD;
                        end else if (r_lenblk) begin
                            r_oi    <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_lenblk <= 1'b1;
                            r_wi     <= '0;
                            r_state  <= S_FILL;
                        end
                    end else begin
                        r_cnt <= r_cnt + 3'd1;
                    end
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_oi <= r_oi + 2'd1;
                        if (r_oi == 2'd3) begin
                            r_cv_valid <= '0;
                            r_fill     <= '0;
                            r_msg      <= '0;
                            r_fin      <= 1'b0;
                            r_padded   <= 1'b0;
                            r_lenblk   <= 1'b0;
                            r_state    <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready              = (r_state == S_IDLE);
    assign o_out_valid             = (r_state == S_OUT);
    assign o_out_item.digest_word  = r_v[r_oi];
    assign o_out_item.word_index   = r_oi;
    assign o_out_item.last_word    = (r_oi == 2'd3);

endmodule

// ===== sv/md4_checker.sv =====
// ----------------------------------------------------------------------------
// md4_checker
// Port-level assertions for the MD4 hash engine, bound to the top level.
// ----------------------------------------------------------------------------
module md4_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input md4_pkg::t_out_item o_out_item
);

    // a result item holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("output item changed while stalled");

    // no input is taken while the digest is being delivered
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input ready during digest output");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.last_word == (o_out_item.word_index == 2'd3)))
        else $error("last_word does not match word_index");

    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out_item.last_word
        |=> o_out_valid && (o_out_item.word_index == $past(o_out_item.word_index) + 2'd1))
        else $error("digest words out of order");

    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_out_item.last_word |=> !o_out_valid && o_in_ready)
        else $error("engine not idle after last digest word");

endmodule

bind md4_hash_engine md4_checker u_md4_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

// ===== dv/md4_hash_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// md4_hash_checker
// Watches both channels of the MD4 engine, keeps its own digest state and
// compares every digest word with the oldest one predicted.
// ----------------------------------------------------------------------------
module md4_hash_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  md4_pkg::t_in_item  i_in_item,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  md4_pkg::t_out_item i_out_item,
    output int                 o_fail_count,
    output int                 o_pending
);

    logic [31:0]        chain [4];
    logic [7:0]         blk [64];
    int unsigned        fill;
    logic [60:0]        msg_len;
    md4_pkg::t_out_item digest_q [$];

    function automatic logic [31:0] rol(logic [31:0] v, int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    task automatic compress();
        logic [31:0] m [16];
        logic [31:0] v [4];
        logic [31:0] x, y, z, f, k;
        int t, rnd;
        for (int i = 0; i < 16; i++)
            m[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
        for (int i = 0; i < 4; i++) v[i] = chain[i];
        for (int i = 0; i < md4_pkg::STEPS; i++) begin
            t = (4 - (i & 3)) & 3;
            x = v[(t + 1) & 3];
            y = v[(t + 2) & 3];
            z = v[(t + 3) & 3];
            rnd = i / 16;
            if (rnd == 0) begin
                f = (x & y) | (~x & z);
                k = '0;
            end else if (rnd == 1) begin
                f = (x & y) | (x & z) | (y & z);
                k = md4_pkg::K_G;
            end else begin
                f = x ^ y ^ z;
                k = md4_pkg::K_H;
            end
            v[t] = rol(v[t] + f + m[md4_pkg::WORD_ORDER[i]] + k,
                       md4_pkg::ROT_AMOUNT[rnd*4 + (i & 3)]);
        end
        for (int i = 0; i < 4; i++) chain[i] = chain[i] + v[i];
    endtask

    task automatic restart();
        for (int i = 0; i < 4; i++) chain[i] = md4_pkg::IV[i];
        fill = 0;
        msg_len = '0;
    endtask

    task automatic absorb(md4_pkg::t_in_item it);
        logic [63:0]        bit_len;
        md4_pkg::t_out_item w;
        if (it.has_byte) begin
            blk[fill] = it.data_byte;
            fill++;
            msg_len++;
            if (fill == 64) begin
                compress();
                fill = 0;
            end
        end
        if (it.end_of_message) begin
            bit_len = {msg_len, 3'b000};
            blk[fill] = md4_pkg::PAD_BYTE;
            fill++;
            if (fill > 56) begin
                for (int i = fill; i < 64; i++) blk[i] = '0;
                compress();
                fill = 0;
            end
            for (int i = fill; i < 56; i++) blk[i] = '0;
            for (int i = 0; i < 8; i++) blk[56 + i] = bit_len[8*i +: 8];
            compress();
            for (int i = 0; i < 4; i++) begin
                w.digest_word = chain[i];
                w.word_index  = 2'(i);
                w.last_word   = (i == 3);
                digest_q.push_back(w);
            end
            restart();
        end
    endtask

    initial begin
        o_fail_count = 0;
        restart();
    end

    assign o_pending = digest_q.size();

    always @(posedge i_clk) begin
        md4_pkg::t_out_item want;
        if (!i_rst_n) begin
            restart();
            digest_q.delete();
        end else begin
            if (i_in_valid && i_in_ready) absorb(i_in_item);
            if (i_out_valid && i_out_ready) begin
                if (digest_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected digest word %h idx %0d last %0b",
                                 i_out_item.digest_word, i_out_item.word_index,
                                 i_out_item.last_word);
                end else begin
                    want = digest_q.pop_front();
                    if (i_out_item !== want) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("digest mismatch: exp %h/%0d/%0b got %h/%0d/%0b",
                                     want.digest_word, want.word_index, want.last_word,
                                     i_out_item.digest_word, i_out_item.word_index,
                                     i_out_item.last_word);
                    end
                end
            end
        end
    end
endmodule

// ===== dv/tb_md4_hash_engine.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_md4_hash_engine
// Feeds messages of directed and random lengths into the MD4 engine with
// random gaps and output stalls; the checker predicts and compares digests.
// ----------------------------------------------------------------------------
module tb_md4_hash_engine;

    localparam int IDLE_LIMIT = 5000;

    logic               i_clk;
    logic               i_rst_n;
    logic               in_valid;
    logic               in_ready;
    md4_pkg::t_in_item  in_item;
    logic               out_valid;
    logic               out_ready;
    md4_pkg::t_out_item out_item;
    int                 fail_count;
    int                 pending;
    int                 idle_cycles;
    int                 stall_mode;
    int                 burst_left;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    md4_hash_engine u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    md4_hash_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_item  (out_item),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // receiver stall pattern: phases of always-ready, random, and mostly-stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready  <= 1'b0;
            stall_mode <= 0;
        end else begin
            if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom_range(0, 1));
                default: out_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || in_valid && in_ready || out_valid && out_ready)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // present one item; valid drops only in the gaps between bursts
    task automatic send(logic [7:0] b, logic has, logic fin);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_valid          <= 1'b1;
        in_item.data_byte <= b;
        in_item.has_byte  <= has;
        in_item.end_of_message <= fin;
        do @(posedge i_clk); while (!in_ready);
    endtask

    task automatic send_msg(int len, int noise);
        for (int i = 0; i < len; i++) begin
            if (noise && $urandom_range(0, 9) == 0) send(8'($urandom), 1'b0, 1'b0);
            send(8'($urandom), 1'b1, 1'b0);
        end
        send(8'($urandom), 1'b0, 1'b1);
    endtask

    initial begin
        int lens [4] = '{55, 56, 63, 64};
        int sent;
        i_rst_n     = 1'b0;
        in_valid    = 1'b0;
        in_item     = '0;
        burst_left  = 0;
        idle_cycles = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty message, extremes of byte, ignored item, fin with byte
        send(8'hff, 1'b0, 1'b1);
        send(8'h00, 1'b1, 1'b0);
        send(8'h5a, 1'b0, 1'b0);
        send(8'hff, 1'b1, 1'b1);
        send(8'haa, 1'b1, 1'b0);
        send(8'h55, 1'b1, 1'b1);
        for (int i = 0; i < 4; i++) send_msg(lens[i], 0);

        // random messages, mostly short, some crossing a block boundary
        sent = 0;
        while (sent < 110) begin
            int len;
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 70)
                                              : $urandom_range(0, 20);
            if ($urandom_range(0, 3) == 0 && len > 0) begin
                send_msg(len - 1, 1);
                send(8'($urandom), 1'b1, 1'b1);
            end else begin
                send_msg(len, 1);
            end
            sent += len + 1;
        end
        in_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
